// ===== design/lsds_pkg.sv =====
// types and constants shared by the line-sensor differential steering block
// no dependencies
package lsds_pkg;

  localparam int unsigned SENSOR_W = 8;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned COUNT_W  = 3;

  // configuration register indexes
  localparam logic CFG_BASE_SPEED = 1'b0;
  localparam logic CFG_MAX_SPEED  = 1'b1;

  localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd128;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 8'd255;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_bits;
    logic                collision;
  } lsds_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               stopped;
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] right_count;
  } lsds_out_t;

endpackage

// ===== design/line_sensor_differential_steering.sv =====
// line-sensor differential steering: top level, one register stage
// depends on lsds_pkg (payload structs, register indexes, reset values)
// a result is registered and appears on the output in the cycle after its input transaction is taken
// throughput: one transaction per cycle while out_ready_i does not stall, set by the single result register
// in_ready_o stays high while the result register is empty or being drained
// reset (rst_ni low, asynchronous): output empty, base_speed 128, max_speed 255
module line_sensor_differential_steering #(
  parameter int unsigned SENSORS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lsds_pkg::lsds_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lsds_pkg::lsds_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [lsds_pkg::SPEED_W-1:0] cfg_data_i
);

  localparam int unsigned SW = lsds_pkg::SPEED_W;
  localparam int unsigned CW = lsds_pkg::COUNT_W;

  // geometry: c is the rounded-up half, center sensors per side
  localparam int unsigned C      = SENSORS - SENSORS / 2;
  localparam bit          EVEN   = (SENSORS % 2) == 0;
  localparam int unsigned LC     = C - 1;
  localparam int unsigned RC     = EVEN ? C : C - 1;
  localparam int unsigned RSTART = EVEN ? C + 1 : C;
  // outermost weight, at least one
  localparam int unsigned W      = ((SENSORS - 1) / 2 < 1) ? 1 : (SENSORS - 1) / 2;
  // reciprocal of the weight, 16 fraction bits, exact for 8-bit dividends
  localparam int unsigned RECIP_W = 17;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((65536 + W - 1) / W);
  localparam logic [SW-1:0] QUOT_RST = SW'(255 / W);

  // configuration registers
  logic [SW-1:0] base_q, base_d;
  logic [SW-1:0] max_q, max_d;
  // max_speed / weight, refreshed whenever max_speed is written
  logic [SW-1:0] quot_q, quot_d;
  logic [SW+RECIP_W-1:0] quot_prod;

  always_comb begin
    base_d = base_q;
    max_d  = max_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        lsds_pkg::CFG_BASE_SPEED: base_d = cfg_data_i;
        lsds_pkg::CFG_MAX_SPEED:  max_d  = cfg_data_i;
        default: ;
      endcase
    end
    quot_prod = (SW + RECIP_W)'(max_d) * (SW + RECIP_W)'(RECIP);
    quot_d    = quot_prod[16 +: SW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= lsds_pkg::BASE_SPEED_RST;
      max_q  <= lsds_pkg::MAX_SPEED_RST;
      quot_q <= QUOT_RST;
    end else begin
      base_q <= base_d;
      max_q  <= max_d;
      quot_q <= quot_d;
    end
  end

  // sensor row, sensors beyond the input field read as zero
  logic [SENSORS-1:0] sens;
  always_comb begin
    for (int i = 0; i < SENSORS; i++) begin
      if (i < lsds_pkg::SENSOR_W) sens[i] = in_data_i.sensor_bits[i];
      else                         sens[i] = 1'b0;
    end
  end

  // a side sensor counts when it equals its inner neighbour and that side's center
  logic [SENSORS-1:0] lmatch, rmatch;
  logic [CW-1:0]      lcnt, rcnt;
  always_comb begin
    lmatch = '0;
    rmatch = '0;
    for (int i = 0; i + 1 < C; i++) begin
      lmatch[i] = (sens[i] == sens[i+1]) && (sens[i] == sens[LC]);
    end
    for (int i = RSTART; i < SENSORS; i++) begin
      rmatch[i] = (sens[i] == sens[i-1]) && (sens[i] == sens[RC]);
    end
    lcnt = '0;
    rcnt = '0;
    for (int i = 0; i < SENSORS; i++) begin
      lcnt = lcnt + CW'(lmatch[i]);
      rcnt = rcnt + CW'(rmatch[i]);
    end
  end

  // steering: magnitude of the difference, then add/subtract and clamp
  logic          steer_right;
  logic [CW-1:0] cnt_mag;
  logic [SW+CW-1:0] diff_raw;
  logic [SW-1:0] diff_mag;
  logic [SW:0]   sum_up;
  logic [SW-1:0] spd_up, spd_dn;
  lsds_pkg::lsds_out_t res;

  always_comb begin
    steer_right = rcnt > lcnt;
    cnt_mag     = steer_right ? (rcnt - lcnt) : (lcnt - rcnt);
    diff_raw    = (SW + CW)'(quot_q) * (SW + CW)'(cnt_mag);
    diff_mag    = (diff_raw > (SW + CW)'(max_q)) ? max_q : diff_raw[SW-1:0];
    // side that speeds up
    sum_up = (SW + 1)'(base_q) + (SW + 1)'(diff_mag);
    spd_up = (sum_up > (SW + 1)'(max_q)) ? max_q : sum_up[SW-1:0];
    // side that slows down, floored at zero
    if (base_q < diff_mag)                spd_dn = '0;
    else if (base_q - diff_mag > max_q)   spd_dn = max_q;
    else                                  spd_dn = base_q - diff_mag;

    res.left_count  = lcnt;
    res.right_count = rcnt;
    res.stopped     = in_data_i.collision;
    if (in_data_i.collision) begin
      res.left_speed  = '0;
      res.right_speed = '0;
    end else if (lcnt == rcnt) begin
      // balanced: base speed, not clamped
      res.left_speed  = base_q;
      res.right_speed = base_q;
    end else if (steer_right) begin
      res.right_speed = spd_up;
      res.left_speed  = spd_dn;
    end else begin
      res.right_speed = spd_dn;
      res.left_speed  = spd_up;
    end
  end

  // result register with a valid flag
  logic                out_valid_q, out_valid_d;
  lsds_pkg::lsds_out_t out_q;
  logic                in_fire;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // a collision transaction comes out stopped with both speeds at zero
  a_collision_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.collision |=>
      out_valid_o && out_data_o.stopped &&
      out_data_o.left_speed == '0 && out_data_o.right_speed == '0)
    else $error("collision did not stop both sides");

  // stopped flag follows the collision bit of the transaction taken
  a_stop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_data_o.stopped == $past(in_data_i.collision))
    else $error("stopped flag does not match collision");

  // balanced counts give equal speeds
  a_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.stopped &&
    out_data_o.left_count == out_data_o.right_count |->
      out_data_o.left_speed == out_data_o.right_speed)
    else $error("balanced counts gave unequal speeds");

  // steered speeds never exceed max_speed
  a_speed_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.stopped &&
    out_data_o.left_count != out_data_o.right_count && !$past(cfg_we_i) |->
      out_data_o.left_speed <= max_q && out_data_o.right_speed <= max_q)
    else $error("steered speed above max_speed");

  // an empty result register never stalls the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");
`endif

endmodule

// ===== tb/tb_line_sensor_differential_steering.sv =====
// self-checking testbench for line_sensor_differential_steering
// depends on lsds_pkg and the design top; a scoreboard class predicts each result
module tb_line_sensor_differential_steering;

  localparam int SENSORS = 8;
  localparam int HOLD_CYCLES = 60;
  localparam int SENSOR_W = lsds_pkg::SENSOR_W;
  localparam int SPEED_W  = lsds_pkg::SPEED_W;
  localparam int COUNT_W  = lsds_pkg::COUNT_W;

  // scoreboard: own copy of the speed registers, predicted results in order
  class steer_scoreboard;
    lsds_pkg::lsds_out_t due_speeds[$];
    int unsigned errors;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] max_speed;

    function new();
      errors = 0;
      base_speed = lsds_pkg::BASE_SPEED_RST;
      max_speed = lsds_pkg::MAX_SPEED_RST;
    endfunction

    function void write_cfg(logic idx, logic [SPEED_W-1:0] val);
      if (idx == lsds_pkg::CFG_BASE_SPEED) base_speed = val;
      else if (idx == lsds_pkg::CFG_MAX_SPEED) max_speed = val;
    endfunction

    // sensors beyond the input width read as 0
    function logic sensor_at(logic [SENSOR_W-1:0] bits, int i);
      if (i < 0 || i >= SENSOR_W) return 1'b0;
      return bits[i];
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function lsds_pkg::lsds_out_t steer(lsds_pkg::lsds_in_t t);
      lsds_pkg::lsds_out_t r;
      int c, rc_idx, rstart, lcnt, rcnt, w, diff, lspd, rspd;
      logic lref, rref, s;
      c = SENSORS - SENSORS / 2;
      rc_idx = (SENSORS % 2 == 0) ? c : c - 1;
      rstart = (SENSORS % 2 == 0) ? c + 1 : c;
      lref = sensor_at(t.sensor_bits, c - 1);
      rref = sensor_at(t.sensor_bits, rc_idx);
      lcnt = 0;
      rcnt = 0;
      // left side walks outward from the center, right side likewise
      for (int i = c - 2; i >= 0; i--) begin
        s = sensor_at(t.sensor_bits, i);
        if (s == sensor_at(t.sensor_bits, i + 1) && s == lref) lcnt++;
      end
      for (int i = rstart; i < SENSORS; i++) begin
        s = sensor_at(t.sensor_bits, i);
        if (s == sensor_at(t.sensor_bits, i - 1) && s == rref) rcnt++;
      end
      if (t.collision) begin
        lspd = 0;
        rspd = 0;
      end else if (lcnt == rcnt) begin
        // balanced: base speed as is, even above max_speed
        lspd = base_speed;
        rspd = base_speed;
      end else begin
        w = (SENSORS - 1) / 2;
        if (w < 1) w = 1;
        diff = (int'(max_speed) / w) * (rcnt - lcnt);
        diff = clamp(diff, -int'(max_speed), int'(max_speed));
        rspd = clamp(int'(base_speed) + diff, 0, int'(max_speed));
        lspd = clamp(int'(base_speed) - diff, 0, int'(max_speed));
      end
      r.left_speed = lspd[SPEED_W-1:0];
      r.right_speed = rspd[SPEED_W-1:0];
      r.stopped = t.collision;
      r.left_count = lcnt[COUNT_W-1:0];
      r.right_count = rcnt[COUNT_W-1:0];
      return r;
    endfunction

    function void note_input(lsds_pkg::lsds_in_t t);
      due_speeds.push_back(steer(t));
    endfunction

    function void check_result(lsds_pkg::lsds_out_t got);
      lsds_pkg::lsds_out_t want;
      if (due_speeds.size() == 0) begin
        $error("result with no transaction pending: %h", got);
        errors++;
        return;
      end
      want = due_speeds.pop_front();
      if (got.left_speed !== want.left_speed) begin
        $error("left_speed: expected %0d, actual %0d", want.left_speed, got.left_speed);
        errors++;
      end
      if (got.right_speed !== want.right_speed) begin
        $error("right_speed: expected %0d, actual %0d", want.right_speed, got.right_speed);
        errors++;
      end
      if (got.stopped !== want.stopped) begin
        $error("stopped: expected %0d, actual %0d", want.stopped, got.stopped);
        errors++;
      end
      if (got.left_count !== want.left_count) begin
        $error("left_count: expected %0d, actual %0d", want.left_count, got.left_count);
        errors++;
      end
      if (got.right_count !== want.right_count) begin
        $error("right_count: expected %0d, actual %0d", want.right_count, got.right_count);
        errors++;
      end
    endfunction

    function int pending();
      return due_speeds.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  lsds_pkg::lsds_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  lsds_pkg::lsds_out_t out_data_o;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [SPEED_W-1:0]  cfg_data_i;

  steer_scoreboard sb;

  // receiver behavior, set by the main sequence
  int unsigned rx_stall_pct;
  int unsigned hold_reqs;

  line_sensor_differential_steering #(
    .SENSORS(SENSORS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock, period 2
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // monitor: both handshakes sampled at the rising edge, before the design updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  // receiver: random stall bursts, plus one long hold-off per request
  initial begin
    int unsigned holds_done;
    holds_done  = 0;
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // register write, one cycle of write enable
  task automatic write_reg(input logic idx, input logic [SPEED_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_cfg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_speeds(input logic [SPEED_W-1:0] base, input logic [SPEED_W-1:0] vmax);
    write_reg(lsds_pkg::CFG_BASE_SPEED, base);
    write_reg(lsds_pkg::CFG_MAX_SPEED, vmax);
  endtask

  // offer one transaction after an optional idle gap, return once accepted
  task automatic send_item(input lsds_pkg::lsds_in_t item, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_data_i.sensor_bits <= SENSOR_W'($urandom);
      in_data_i.collision   <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // line-like snapshots reach every count, fully random ones fill the rest
  function automatic lsds_pkg::lsds_in_t random_snapshot();
    lsds_pkg::lsds_in_t t;
    int unsigned lo, len;
    logic [15:0] run;
    lo  = $urandom_range(0, SENSOR_W - 1);
    len = $urandom_range(1, SENSOR_W);
    run = ((16'd1 << len) - 16'd1) << lo;
    case ($urandom_range(0, 3))
      0: t.sensor_bits = SENSOR_W'($urandom);
      1: t.sensor_bits = run[SENSOR_W-1:0];
      2: t.sensor_bits = ~run[SENSOR_W-1:0];
      default: t.sensor_bits = run[SENSOR_W-1:0] ^ (SENSOR_W'(1) << $urandom_range(0, 7));
    endcase
    t.collision = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  task automatic run_random(input int n, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    int unsigned gap;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 11) : 0;
      send_item(random_snapshot(), gap);
    end
    stop_sending();
  endtask

  // wait for every expected result, then let the output stage settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // directed snapshots: extremes, centered line, hard turns
  logic [SENSOR_W-1:0] directed_bits[20] = '{
    8'h00, 8'hFF, 8'h18, 8'hE7, 8'h0F, 8'hF0, 8'h07, 8'hE0, 8'h01, 8'h80,
    8'h55, 8'hAA, 8'h1F, 8'hF8, 8'h3C, 8'h0E, 8'h70, 8'h08, 8'h10, 8'hC3
  };

  // register settings per phase: zero, full, base above max, zero base, tiny max
  logic [SPEED_W-1:0] phase_base[7] = '{8'd0,   8'd255, 8'd255, 8'd0,   8'd200, 8'd10, 8'd90};
  logic [SPEED_W-1:0] phase_max[7]  = '{8'd0,   8'd255, 8'd0,   8'd255, 8'd100, 8'd2,  8'd3};

  initial begin
    lsds_pkg::lsds_in_t t;
    sb = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = lsds_pkg::CFG_BASE_SPEED;
    cfg_data_i   = '0;
    rx_stall_pct = 0;
    hold_reqs    = 0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed part at the reset settings, back to back
    foreach (directed_bits[i]) begin
      t.sensor_bits = directed_bits[i];
      t.collision   = 1'b0;
      send_item(t, 0);
    end
    t.sensor_bits = 8'hFF;
    t.collision   = 1'b1;
    send_item(t, 0);
    t.sensor_bits = 8'h00;
    send_item(t, 0);
    t.sensor_bits = 8'h07;
    send_item(t, 0);
    stop_sending();
    drain();

    // fixed settings, random idling on both sides
    foreach (phase_base[i]) begin
      set_speeds(phase_base[i], phase_max[i]);
      run_random(145, $urandom_range(0, 50), $urandom_range(0, 50));
      drain();
      // long receiver hold-off while the sender keeps offering
      if (i == 3) begin
        hold_reqs++;
        run_random(40, 0, 0);
        drain();
      end
    end

    // random settings
    repeat (3) begin
      set_speeds(SPEED_W'($urandom), SPEED_W'($urandom));
      run_random(145, $urandom_range(0, 50), $urandom_range(0, 50));
      drain();
    end

    // last part: no idling anywhere
    set_speeds(SPEED_W'($urandom), SPEED_W'($urandom));
    run_random(150, 0, 0);
    drain();
    repeat (4) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_line_sensor_differential_steering passed");
    end else begin
      $display("tb_line_sensor_differential_steering failed");
    end
    $finish;
  end

  // run limit well above the slowest correct run
  initial begin
    #1000000;
    $display("tb_line_sensor_differential_steering failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/lsds_pkg.sv
design/line_sensor_differential_steering.sv
tb/tb_line_sensor_differential_steering.sv
